// ===== design/wft_pkg.sv =====
// Shared types and constants for the Wiegand frame transmitter.
// No dependencies; imported by every module of the block.
`default_nettype none

package wft_pkg;

   localparam int unsigned MAX_DATA_BITS = 62;
   localparam int unsigned FRAME_W       = 64;
   localparam int unsigned COUNT_W       = 6;
   localparam int unsigned CARD_W        = 62;
   localparam int unsigned PHASE_W       = 7;
   localparam int unsigned TICK_W        = 16;
   localparam int unsigned CSR_ADDR_W    = 4;
   localparam int unsigned CSR_DATA_W    = 32;

   // request operation codes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SEND = 1'b1;

   // configuration register indexes
   localparam logic [1:0] REG_PULSE_LOW = 2'd0;
   localparam logic [1:0] REG_PULSE_GAP = 2'd1;
   localparam logic [1:0] REG_LEAD_IDLE = 2'd2;

   localparam logic [TICK_W-1:0] PULSE_LOW_RESET = 16'd100;
   localparam logic [TICK_W-1:0] PULSE_GAP_RESET = 16'd1500;
   localparam logic [TICK_W-1:0] LEAD_IDLE_RESET = 16'd10100;

   // line level codes: bit 0 = DATA0, bit 1 = DATA1
   localparam logic [1:0] LINES_IDLE     = 2'b11;
   localparam logic [1:0] LINES_ZERO_LOW = 2'b10;
   localparam logic [1:0] LINES_ONE_LOW  = 2'b01;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_TOO_LARGE = 2'd1,
      ERR_ODD       = 2'd2,
      ERR_BUSY      = 2'd3
   } err_type;

   typedef struct packed {
      logic [TICK_W-1:0] pulse_low;
      logic [TICK_W-1:0] pulse_gap;
      logic [TICK_W-1:0] lead_idle;
   } cfg_type;

   typedef struct packed {
      logic    line_zero;
      logic    line_one;
      logic    busy;
      logic    done;
      err_type error;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/wft_csr.sv =====
// Configuration registers of the Wiegand transmitter, APB-style access.
// Depends on wft_pkg.
`default_nettype none

module wft_csr
   import wft_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_PULSE_LOW: cfg_in.pulse_low = pwdata[TICK_W-1:0];
            REG_PULSE_GAP: cfg_in.pulse_gap = pwdata[TICK_W-1:0];
            REG_LEAD_IDLE: cfg_in.lead_idle = pwdata[TICK_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_PULSE_LOW: prdata = CSR_DATA_W'(cfg_ff.pulse_low);
         REG_PULSE_GAP: prdata = CSR_DATA_W'(cfg_ff.pulse_gap);
         REG_LEAD_IDLE: prdata = CSR_DATA_W'(cfg_ff.lead_idle);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_low <= PULSE_LOW_RESET;
         cfg_ff.pulse_gap <= PULSE_GAP_RESET;
         cfg_ff.lead_idle <= LEAD_IDLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== design/wft_frame_build.sv =====
// Frame builder: masks the card number and adds the two half parities.
// Purely combinational; depends on wft_pkg.
`default_nettype none

module wft_frame_build
   import wft_pkg::*;
(
   input  wire logic [COUNT_W-1:0] bit_count,
   input  wire logic [CARD_W-1:0]  card_id,
   output logic      [FRAME_W-1:0] frame,
   output logic      [COUNT_W-1:0] top_idx,
   output logic      [PHASE_W-1:0] last_phase
);

   logic [FRAME_W-1:0] data_mask;
   logic [FRAME_W-1:0] half_mask;
   logic [FRAME_W-1:0] data;
   logic [COUNT_W-2:0] half;
   logic               upper_par;
   logic               lower_par;
   logic [PHASE_W:0]   phases_wide;

   assign half      = bit_count[COUNT_W-1:1];
   assign data_mask = ~({FRAME_W{1'b1}} << bit_count);
   assign half_mask = ~({FRAME_W{1'b1}} << half);
   assign data      = {{(FRAME_W-CARD_W){1'b0}}, card_id} & data_mask;
   // even parity over the upper half, odd parity over the lower half
   assign upper_par = ^(data & ~half_mask);
   assign lower_par = ^(data & half_mask);

   assign top_idx   = bit_count + COUNT_W'(1);
   assign frame     = (FRAME_W'(upper_par) << top_idx) | (data << 1) |
                      {{(FRAME_W-1){1'b0}}, ~lower_par};

   assign phases_wide = ((PHASE_W+1)'(bit_count) + (PHASE_W+1)'(2)) << 1;
   assign last_phase  = phases_wide[PHASE_W-1:0] - PHASE_W'(1);

endmodule

`default_nettype wire

// ===== design/wft_engine.sv =====
// Frame sequencer state: validates send requests, runs the tick timer and
// drives the line levels. Depends on wft_pkg and wft_frame_build.
`default_nettype none

module wft_engine
   import wft_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step_en,
   input  wire logic               operation,
   input  wire logic [COUNT_W-1:0] bit_count,
   input  wire logic [CARD_W-1:0]  card_id,
   input  wire cfg_type            cfg,
   output rsp_type                 rsp
);

   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [COUNT_W-1:0] top_idx_ff, top_idx_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [PHASE_W-1:0] last_phase_ff, last_phase_in;
   logic [TICK_W-1:0]  timer_ff, timer_in;
   logic               sending_ff, sending_in;
   logic               in_lead_ff, in_lead_in;
   logic [1:0]         lines_ff, lines_in;

   logic [FRAME_W-1:0] new_frame;
   logic [COUNT_W-1:0] new_top_idx;
   logic [PHASE_W-1:0] new_last_phase;
   logic               cur_bit;
   logic               done;
   err_type            err;

   wft_frame_build u_frame_build (
      .bit_count  (bit_count),
      .card_id    (card_id),
      .frame      (new_frame),
      .top_idx    (new_top_idx),
      .last_phase (new_last_phase)
   );

   assign cur_bit = frame_ff[top_idx_ff];

   always_comb begin
      frame_in      = frame_ff;
      top_idx_in    = top_idx_ff;
      phase_in      = phase_ff;
      last_phase_in = last_phase_ff;
      timer_in      = timer_ff;
      sending_in    = sending_ff;
      in_lead_in    = in_lead_ff;
      lines_in      = lines_ff;
      done          = 1'b0;
      err           = ERR_NONE;

      if (operation == OP_SEND) begin
         priority if (bit_count > COUNT_W'(MAX_DATA_BITS)) begin
            err = ERR_TOO_LARGE;
         end else if (bit_count[0]) begin
            err = ERR_ODD;
         end else if (sending_ff) begin
            err = ERR_BUSY;
         end else begin
            frame_in      = new_frame;
            top_idx_in    = new_top_idx;
            last_phase_in = new_last_phase;
            phase_in      = '0;
            timer_in      = cfg.lead_idle;
            sending_in    = 1'b1;
            in_lead_in    = 1'b1;
            lines_in      = LINES_IDLE;
         end
      end else if (sending_ff) begin
         if (timer_ff > TICK_W'(1)) begin
            timer_in = timer_ff - TICK_W'(1);
         end else if (in_lead_ff && (phase_ff != '0)) begin
            // tail wait over: frame complete
            lines_in   = LINES_IDLE;
            sending_in = 1'b0;
            in_lead_in = 1'b0;
            phase_in   = '0;
            done       = 1'b1;
         end else begin
            in_lead_in = 1'b0;
            if (!phase_ff[0]) begin
               lines_in = cur_bit ? LINES_ONE_LOW : LINES_ZERO_LOW;
               timer_in = cfg.pulse_low;
               phase_in = phase_ff + PHASE_W'(1);
            end else begin
               lines_in = LINES_IDLE;
               timer_in = cfg.pulse_gap;
               frame_in = frame_ff << 1;
               if (phase_ff == last_phase_ff) begin
                  in_lead_in = 1'b1;
               end else begin
                  phase_in = phase_ff + PHASE_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff      <= '0;
         top_idx_ff    <= '0;
         phase_ff      <= '0;
         last_phase_ff <= '0;
         timer_ff      <= '0;
         sending_ff    <= 1'b0;
         in_lead_ff    <= 1'b0;
         lines_ff      <= LINES_IDLE;
      end else if (step_en) begin
         frame_ff      <= frame_in;
         top_idx_ff    <= top_idx_in;
         phase_ff      <= phase_in;
         last_phase_ff <= last_phase_in;
         timer_ff      <= timer_in;
         sending_ff    <= sending_in;
         in_lead_ff    <= in_lead_in;
         lines_ff      <= lines_in;
      end
   end

   assign rsp.line_zero = lines_in[0];
   assign rsp.line_one  = lines_in[1];
   assign rsp.busy      = sending_in;
   assign rsp.done      = done;
   assign rsp.error     = err;

endmodule

`default_nettype wire

// ===== design/wiegand_frame_transmitter_top.sv =====
// Top level of the Wiegand frame transmitter: request/response pipeline,
// configuration port. Depends on wft_pkg, wft_csr and wft_engine.
`default_nettype none

// Usage notes
// - Request channel (req_*): operation 0 is one time tick, operation 1 a send
//   request carrying bit_count and card_id. Every request gives exactly one
//   response (rsp_*) with both line levels, busy, done and an error code.
// - Ticks come from a timebase; the block absorbs one request per cycle unless stalled.
// - Path: an accepted request is taken into the input register, processed
//   when the response slot is free, then registered in the response register.
// - Throughput: one request per cycle, sustained while responses are taken. The
//   single-pass step (frame build with half parities, timer and phase update)
//   sits between the input register and the response register.
// - Stall: when rsp_ready is low the response register holds; one more
//   request can wait in the input register, then req_ready drops until the
//   response is taken. Nothing is dropped or repeated.
// - Reset (synchronous, active high): lines high, no frame in progress,
//   pipeline empty, timing registers at 100 / 1500 / 10100 ticks.
// - Configuration: APB-style, registers at byte addresses 0, 4, 8
//   (pulse low, pulse gap, lead idle). Write only while idle; a new value
//   is used from the next timer load.

module wiegand_frame_transmitter_top
   import wft_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_operation,
   input  wire logic [COUNT_W-1:0]    req_bit_count,
   input  wire logic [CARD_W-1:0]     req_card_id,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_line_zero,
   output logic                       rsp_line_one,
   output logic                       rsp_busy_res,
   output logic                       rsp_done_res,
   output logic [1:0]                 rsp_error_code,
   // configuration port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   cfg_type cfg;
   rsp_type step_rsp;

   // input register
   logic               in_valid_ff, in_valid_in;
   logic               in_op_ff;
   logic [COUNT_W-1:0] in_count_ff;
   logic [CARD_W-1:0]  in_card_ff;

   // response register
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff;

   logic req_take;
   logic advance;

   // a request moves from the input register into the response register
   // whenever the response slot is empty or being emptied this cycle
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff    <= req_operation;
         in_count_ff <= req_bit_count;
         in_card_ff  <= req_card_id;
      end
      if (advance) begin
         out_ff <= step_rsp;
      end
   end

   wft_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   wft_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .operation (in_op_ff),
      .bit_count (in_count_ff),
      .card_id   (in_card_ff),
      .cfg       (cfg),
      .rsp       (step_rsp)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_line_zero  = out_ff.line_zero;
   assign rsp_line_one   = out_ff.line_one;
   assign rsp_busy_res   = out_ff.busy;
   assign rsp_done_res   = out_ff.done;
   assign rsp_error_code = out_ff.error;

endmodule

`default_nettype wire
